@@ design/tx_retry_response_fsm_defines.svh @@
// Shared assertion macros for the send controller.
`ifndef TX_RETRY_RESPONSE_FSM_DEFINES_SVH
`define TX_RETRY_RESPONSE_FSM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TRR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TRR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/trr_pkg.sv @@
package trr_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] SendDelayRst       = 16'd50;
  localparam logic [15:0] ResponseTimeoutRst = 16'd500;
  localparam logic [3:0]  MaxAttemptsRst     = 4'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEND_DELAY       = 2'd0,
    CFG_RESPONSE_TIMEOUT = 2'd1,
    CFG_MAX_ATTEMPTS     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_DELAY     = 3'd1,
    PH_WAIT_DONE = 3'd2,
    PH_WAIT_RESP = 3'd3,
    PH_ERROR     = 3'd4
  } phase_e;

  typedef struct packed {
    logic [15:0] send_delay;
    logic [15:0] response_timeout;
    logic [3:0]  max_attempts;
  } cfg_t;

  typedef struct packed {
    logic queue_ready;
    logic tx_complete;
    logic response_arrived;
  } in_item_t;

  typedef struct packed {
    logic       take_message;
    logic       start_send;
    logic       clear_complete;
    logic       disable_tx;
    logic [2:0] phase_now;
    logic [3:0] attempts_done;
  } out_item_t;

endpackage

@@ design/trr_in_if.sv @@
interface trr_in_if;
  logic valid;
  logic ready;
  logic queue_ready;
  logic tx_complete;
  logic response_arrived;

  modport source (
    output valid, queue_ready, tx_complete, response_arrived,
    input  ready
  );

  modport sink (
    input  valid, queue_ready, tx_complete, response_arrived,
    output ready
  );
endinterface

@@ design/trr_out_if.sv @@
interface trr_out_if;
  logic       valid;
  logic       ready;
  logic       take_message;
  logic       start_send;
  logic       clear_complete;
  logic       disable_tx;
  logic [2:0] phase_now;
  logic [3:0] attempts_done;

  modport source (
    output valid, take_message, start_send, clear_complete, disable_tx,
           phase_now, attempts_done,
    input  ready
  );

  modport sink (
    input  valid, take_message, start_send, clear_complete, disable_tx,
           phase_now, attempts_done,
    output ready
  );
endinterface

@@ design/tx_retry_response_fsm.sv @@
// The phase update is a single pass; each result is registered in the output buffer.
// Throughput: one tick transaction per clock cycle while the skid entry is empty.
// A two-entry output buffer keeps the input ready while one result waits to be taken.
// Reset clears phase, counters and the response latch, and loads the register defaults
// of 50, 500 and 3; configuration writes take effect on the next cycle.
module tx_retry_response_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  trr_in_if.sink                        in_i,
  trr_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [trr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [trr_pkg::CfgDataW-1:0]  cfg_data_i
);
  import trr_pkg::*;

  cfg_t      cfg;
  in_item_t  item;
  out_item_t res;
  out_item_t out_data;
  logic      in_ready;
  logic      acc;

  assign item.queue_ready      = in_i.queue_ready;
  assign item.tx_complete      = in_i.tx_complete;
  assign item.response_arrived = in_i.response_arrived;
  assign in_i.ready            = in_ready;
  assign acc                   = in_i.valid & in_ready;

  trr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  trr_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .item_i (item),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  trr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .res_i       (res),
    .in_ready_o  (in_ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign out_o.take_message   = out_data.take_message;
  assign out_o.start_send     = out_data.start_send;
  assign out_o.clear_complete = out_data.clear_complete;
  assign out_o.disable_tx     = out_data.disable_tx;
  assign out_o.phase_now      = out_data.phase_now;
  assign out_o.attempts_done  = out_data.attempts_done;

endmodule

@@ design/trr_cfg_regs.sv @@
module trr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [trr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [trr_pkg::CfgDataW-1:0]  cfg_data_i,
  output trr_pkg::cfg_t                 cfg_o
);
  import trr_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SEND_DELAY:       cfg_d.send_delay       = cfg_data_i;
        CFG_RESPONSE_TIMEOUT: cfg_d.response_timeout = cfg_data_i;
        CFG_MAX_ATTEMPTS:     cfg_d.max_attempts     = cfg_data_i[3:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.send_delay       <= SendDelayRst;
      cfg_q.response_timeout <= ResponseTimeoutRst;
      cfg_q.max_attempts     <= MaxAttemptsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/trr_step.sv @@
`include "tx_retry_response_fsm_defines.svh"

module trr_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  trr_pkg::in_item_t  item_i,
  input  trr_pkg::cfg_t      cfg_i,
  output trr_pkg::out_item_t res_o
);
  import trr_pkg::*;

  phase_e      phase_d, phase_q;
  logic [15:0] tick_d, tick_q;
  logic [3:0]  tmo_d, tmo_q;
  logic        latch_d, latch_q;

  logic        latch_v;
  logic [15:0] tick_inc;
  logic [3:0]  tmo_inc;
  logic        check_resp;

  assign latch_v  = latch_q | item_i.response_arrived;
  assign tick_inc = tick_q + 16'd1;
  assign tmo_inc  = tmo_q + 4'd1;

  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    tmo_d      = tmo_q;
    latch_d    = latch_v;
    check_resp = 1'b0;
    case (phase_q)
      PH_DELAY: begin
        tick_d = tick_inc;
        if (tick_inc >= cfg_i.send_delay) begin
          tick_d  = '0;
          phase_d = PH_WAIT_DONE;
        end
      end
      PH_WAIT_DONE: begin
        if (item_i.tx_complete) begin
          tick_d  = '0;
          phase_d = PH_WAIT_RESP;
        end else begin
          check_resp = 1'b1;
        end
      end
      PH_WAIT_RESP: begin
        check_resp = 1'b1;
      end
      PH_ERROR: begin
        latch_d = 1'b0;
        tick_d  = '0;
        tmo_d   = '0;
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
        if (item_i.queue_ready) begin
          tmo_d   = '0;
          tick_d  = '0;
          phase_d = PH_DELAY;
        end
      end
    endcase

    if (check_resp) begin
      if (latch_v) begin
        latch_d = 1'b0;
        tick_d  = '0;
        tmo_d   = '0;
        phase_d = PH_IDLE;
      end else begin
        tick_d = tick_inc;
        if (tick_inc >= cfg_i.response_timeout) begin
          tick_d  = '0;
          tmo_d   = tmo_inc;
          phase_d = (tmo_inc < cfg_i.max_attempts) ? PH_DELAY : PH_ERROR;
        end
      end
    end
  end

  always_comb begin
    res_o.take_message   = 1'b0;
    res_o.start_send     = 1'b0;
    res_o.clear_complete = 1'b0;
    res_o.disable_tx     = 1'b0;
    case (phase_q)
      PH_DELAY:     res_o.start_send     = (tick_inc >= cfg_i.send_delay);
      PH_WAIT_DONE: res_o.clear_complete = item_i.tx_complete;
      PH_WAIT_RESP: res_o.clear_complete = 1'b0;
      PH_ERROR:     res_o.disable_tx     = 1'b1;
      default:      res_o.take_message   = item_i.queue_ready;
    endcase
    res_o.phase_now     = phase_d;
    res_o.attempts_done = tmo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      tmo_q   <= '0;
      latch_q <= 1'b0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      tmo_q   <= tmo_d;
      latch_q <= latch_d;
    end
  end

  `TRR_ASSERT_IMP(a_take_starts_fresh, clk_i, rst_ni, acc_i && res_o.take_message, res_o.phase_now == PH_DELAY && res_o.attempts_done == 4'd0, "taking a message did not start a fresh delay")
  `TRR_ASSERT_NXT(a_error_clears, clk_i, rst_ni, acc_i && phase_q == PH_ERROR, phase_q == PH_IDLE && tmo_q == 4'd0 && tick_q == 16'd0 && !latch_q, "error step left state behind")
  `TRR_ASSERT_NXT(a_hold_without_tick, clk_i, rst_ni, !acc_i, $stable(phase_q) && $stable(tick_q) && $stable(tmo_q) && $stable(latch_q), "state moved without an accepted transaction")

endmodule

@@ design/trr_out_stage.sv @@
module trr_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  trr_pkg::out_item_t res_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output trr_pkg::out_item_t out_data_o
);
  import trr_pkg::*;

  logic      main_vld_d, main_vld_q;
  logic      skid_vld_d, skid_vld_q;
  out_item_t main_d, main_q;
  out_item_t skid_d, skid_q;

  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (main_vld_q && out_ready_i) begin
      if (skid_vld_q) begin
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end else if (acc_i) begin
        main_d = res_i;
      end else begin
        main_vld_d = 1'b0;
      end
    end else if (!main_vld_q) begin
      if (acc_i) begin
        main_d     = res_i;
        main_vld_d = 1'b1;
      end
    end else if (acc_i) begin
      skid_d     = res_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign in_ready_o  = !skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;

endmodule
